@@ rtl/regular_polygon_vertex_generator_assert.svh @@
// assertion macros for the regular polygon vertex generator
// expects signals named clk and rst_n in the scope of use
`ifndef REGULAR_POLYGON_VERTEX_GENERATOR_ASSERT_SVH
`define REGULAR_POLYGON_VERTEX_GENERATOR_ASSERT_SVH

// same-cycle implication, checked out of reset
`define RPVG_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, checked out of reset
`define RPVG_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ rtl/rpvg_pkg.sv @@
// shared constants, types and tables of the polygon vertex generator
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package rpvg_pkg;

    localparam int MAX_SIDES    = 16;
    localparam int ANGLE_BITS   = 16;
    localparam int CORDIC_STEPS = 18;

    localparam int SIDE_W    = $clog2(MAX_SIDES + 1);
    localparam int IDX_W     = $clog2(MAX_SIDES);
    localparam int CORD_W    = 33;
    localparam int CORD_K_W  = $clog2(CORDIC_STEPS);
    localparam int DIV_C_W   = $clog2(ANGLE_BITS + 1);
    localparam int RAD_W     = 11;
    localparam int PROD_W    = CORD_W + RAD_W + 1;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 16;
    localparam int ANG_UP    = (ANGLE_BITS >= 16) ? ANGLE_BITS - 16 : 0;
    localparam int ANG_DN    = (ANGLE_BITS >= 16) ? 0 : 16 - ANGLE_BITS;

    localparam logic [RAD_W-1:0] RADIUS_LOW  = RAD_W'(10);
    localparam logic [RAD_W-1:0] RADIUS_HIGH = RAD_W'(1280);
    localparam logic [RAD_W-1:0] RADIUS_RST  = RAD_W'(100);
    localparam logic [SIDE_W-1:0] SIDES_LOW  = SIDE_W'(3);
    localparam logic [SIDE_W-1:0] SIDES_HIGH = SIDE_W'(MAX_SIDES);
    localparam logic [SIDE_W-1:0] SIDES_RST  = SIDE_W'(6);

    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y    = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS      = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_SIDE_COUNT  = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_START_ANGLE = CFG_IDX_W'(4);

    // gain compensated starting x, q30
    localparam logic signed [CORD_W-1:0] CORDIC_GAIN = CORD_W'(652032874);

    // arctangent of 2^-k in 2^-32 turn units
    localparam logic [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215
    };

    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

endpackage

`default_nettype wire

@@ rtl/rpvg_div.sv @@
// restoring divider: one turn (2^angle_bits) over the side count, one bit a cycle
// depends on rpvg_pkg
`timescale 1ns / 1ps
`default_nettype none

module rpvg_div
    import rpvg_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [SIDE_W-1:0]     divisor,
    output logic [ANGLE_BITS-1:0]      quotient,
    output logic [SIDE_W-1:0]          remainder,
    output unit_stat_t                 stat
);

    logic [DIV_C_W-1:0]    cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [ANGLE_BITS-1:0] quo_reg, quo_next;
    logic [SIDE_W-1:0]     rem_reg, rem_next;
    logic [SIDE_W:0]       shifted;
    logic                  ge;

    always_comb
    begin
        shifted  = {rem_reg, (cnt_reg == DIV_C_W'(ANGLE_BITS))};
        ge       = shifted >= {1'b0, divisor};
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        quo_next = quo_reg;
        rem_next = rem_reg;
        if (start)
        begin
            cnt_next  = DIV_C_W'(ANGLE_BITS);
            busy_next = 1'b1;
            quo_next  = '0;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[ANGLE_BITS-2:0], ge};
            rem_next = ge ? SIDE_W'(shifted - {1'b0, divisor}) : shifted[SIDE_W-1:0];
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - DIV_C_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

`default_nettype wire

@@ rtl/rpvg_cordic.sv @@
// iterative rotation-mode cordic, one micro-rotation a cycle, quadrant fold at output
// depends on rpvg_pkg
`timescale 1ns / 1ps
`default_nettype none

module rpvg_cordic
    import rpvg_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    input  wire logic [31:0]              turn,
    output logic signed [CORD_W-1:0]      sin_q30,
    output logic signed [CORD_W-1:0]      cos_q30,
    output unit_stat_t                    stat
);

    logic signed [CORD_W-1:0] x_reg, x_next;
    logic signed [CORD_W-1:0] y_reg, y_next;
    logic signed [CORD_W-1:0] z_reg, z_next;
    logic [1:0]               quad_reg, quad_next;
    logic [CORD_K_W-1:0]      k_reg, k_next;
    logic                     busy_reg, busy_next;
    logic                     done_reg, done_next;
    logic signed [CORD_W-1:0] dx, dy, da;

    always_comb
    begin
        dx = y_reg >>> k_reg;
        dy = x_reg >>> k_reg;
        da = $signed({1'b0, ATAN_TURNS[k_reg]});
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        quad_next = quad_reg;
        k_next    = k_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            x_next    = CORDIC_GAIN;
            y_next    = '0;
            z_next    = $signed({3'b000, turn[29:0]});
            quad_next = turn[31:30];
            k_next    = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!z_reg[CORD_W-1])
            begin
                x_next = x_reg - dx;
                y_next = y_reg + dy;
                z_next = z_reg - da;
            end
            else
            begin
                x_next = x_reg + dx;
                y_next = y_reg - dy;
                z_next = z_reg + da;
            end
            if (k_reg == CORD_K_W'(CORDIC_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                k_next = k_reg + CORD_K_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg    <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            k_reg    <= k_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        quad_reg <= quad_next;
    end

    // fold the first-quadrant result back to the full turn
    always_comb
    begin
        case (quad_reg)
            2'd0:
            begin
                cos_q30 = x_reg;
                sin_q30 = y_reg;
            end
            2'd1:
            begin
                cos_q30 = -y_reg;
                sin_q30 = x_reg;
            end
            2'd2:
            begin
                cos_q30 = -x_reg;
                sin_q30 = -y_reg;
            end
            default:
            begin
                cos_q30 = y_reg;
                sin_q30 = -x_reg;
            end
        endcase
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

`default_nettype wire

@@ rtl/regular_polygon_vertex_generator.sv @@
// top level of the regular polygon vertex generator: config registers, sequencer,
// shared radius multiplier and output register; depends on rpvg_pkg, rpvg_div,
// rpvg_cordic and regular_polygon_vertex_generator_assert.svh
//
//  channel  | handshake             | payload
//  ---------+-----------------------+----------------------------------------------
//  input    | in_valid / in_ready   | rotation_offset
//  output   | out_valid / out_ready | vertex_x, vertex_y, vertex_index, last
//  config   | cfg_write             | cfg_index, cfg_data (write only)
//
// one transaction in gives side_count transactions out; with no output stall
// the block goes from one accept to the next through the idle state, the
// 17-step divider for the angle step, then per vertex the cordic, the sine
// and cosine multiplier states and one emit
// a vertex waiting in the output register stalls only the emit step
// in_ready is high only while the sequencer is idle; reset is asynchronous
// and needs no clearing pass
`timescale 1ns / 1ps
`default_nettype none
`include "regular_polygon_vertex_generator_assert.svh"

module regular_polygon_vertex_generator
    import rpvg_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_write,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_DAT_W-1:0]   cfg_data,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic signed [15:0]     rotation_offset,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic signed [14:0]          vertex_x,
    output logic signed [14:0]          vertex_y,
    output logic [3:0]                  vertex_index,
    output logic                        last
);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_DIV  = 6'b000010,
        ST_CORD = 6'b000100,
        ST_MULS = 6'b001000,
        ST_MULC = 6'b010000,
        ST_EMIT = 6'b100000
    } state_t;

    // configuration registers
    logic signed [13:0] center_x_reg;
    logic signed [13:0] center_y_reg;
    logic [RAD_W-1:0]   radius_reg;
    logic [SIDE_W-1:0]  side_count_reg;
    logic [15:0]        start_angle_reg;
    logic [RAD_W-1:0]   radius_wr;
    logic [SIDE_W-1:0]  sides_wr;

    // sequencer and per-item state
    state_t                   state_reg, state_next;
    logic [15:0]              acc_rot_reg;
    logic [ANGLE_BITS-1:0]    angle_reg;
    logic [SIDE_W-1:0]        n_item_reg;
    logic [IDX_W-1:0]         i_reg;
    logic [ANGLE_BITS-1:0]    q_reg;
    logic [SIDE_W-1:0]        r_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [15:0]       vx_calc_reg;

    // output register
    logic                     out_valid_reg;
    logic signed [14:0]       out_x_reg;
    logic signed [14:0]       out_y_reg;
    logic [3:0]               out_idx_reg;
    logic                     out_last_reg;

    // datapath nets
    logic                     in_fire;
    logic [15:0]              acc_rot_sum;
    logic [15:0]              total16;
    logic [ANGLE_BITS+15:0]   angle_wide;
    logic [ANGLE_BITS-1:0]    phase;
    logic [ANGLE_BITS-1:0]    q_adv;
    logic [SIDE_W-1:0]        r_adv;
    logic [SIDE_W:0]          r_sum;
    logic                     r_wrap;
    logic                     last_v;
    logic                     slot_free;
    logic                     emit;
    logic                     div_start;
    logic                     cord_start;
    logic [ANGLE_BITS-1:0]    div_quo;
    logic [SIDE_W-1:0]        div_rem;
    unit_stat_t               div_stat;
    unit_stat_t               cord_stat;
    logic signed [CORD_W-1:0] cord_sin;
    logic signed [CORD_W-1:0] cord_cos;
    logic signed [15:0]       vy_calc;

    // round a q30 product half away from zero
    function automatic logic signed [15:0] round_q30(input logic signed [PROD_W-1:0] p);
        logic [PROD_W-1:0] mag;
        logic [PROD_W-1:0] rnd;
        mag = p[PROD_W-1] ? PROD_W'(-p) : PROD_W'(p);
        rnd = (mag + (PROD_W'(1) << 29)) >> 30;
        round_q30 = p[PROD_W-1] ? -$signed(rnd[15:0]) : $signed(rnd[15:0]);
    endfunction

    // clamp radius and side count at write time
    always_comb
    begin
        radius_wr = cfg_data[RAD_W-1:0];
        if (radius_wr < RADIUS_LOW)
        begin
            radius_wr = RADIUS_LOW;
        end
        else if (radius_wr > RADIUS_HIGH)
        begin
            radius_wr = RADIUS_HIGH;
        end
        sides_wr = SIDE_W'(cfg_data[4:0]);
        if (int'(cfg_data[4:0]) < int'(SIDES_LOW))
        begin
            sides_wr = SIDES_LOW;
        end
        else if (int'(cfg_data[4:0]) > MAX_SIDES)
        begin
            sides_wr = SIDES_HIGH;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg    <= '0;
            center_y_reg    <= '0;
            radius_reg      <= RADIUS_RST;
            side_count_reg  <= SIDES_RST;
            start_angle_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_CENTER_X:    center_x_reg    <= $signed(cfg_data[13:0]);
                REG_CENTER_Y:    center_y_reg    <= $signed(cfg_data[13:0]);
                REG_RADIUS:      radius_reg      <= radius_wr;
                REG_SIDE_COUNT:  side_count_reg  <= sides_wr;
                REG_START_ANGLE: start_angle_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    // input transaction: new stored rotation and total angle at angle precision
    assign in_ready    = (state_reg == ST_IDLE);
    assign in_fire     = in_valid && in_ready;
    assign acc_rot_sum = acc_rot_reg + rotation_offset;
    assign total16     = start_angle_reg + acc_rot_sum;
    assign angle_wide  = ({(ANGLE_BITS)'(0), total16} << ANG_UP) >> ANG_DN;

    // next vertex step, round(i * turn / n) kept as quotient plus remainder
    assign r_sum  = {1'b0, r_reg} + {1'b0, div_rem};
    assign r_wrap = r_sum >= {1'b0, n_item_reg};
    assign r_adv  = r_wrap ? SIDE_W'(r_sum - {1'b0, n_item_reg}) : r_sum[SIDE_W-1:0];
    assign q_adv  = q_reg + div_quo + ANGLE_BITS'(r_wrap);

    // phase = half turn - angle + step, taken at the step the cordic starts on
    assign phase = (ANGLE_BITS'(1) << (ANGLE_BITS - 1)) - angle_reg
                   + ((state_reg == ST_EMIT) ? q_adv : q_reg);

    assign last_v     = (SIDE_W'(i_reg) + SIDE_W'(1)) == n_item_reg;
    assign slot_free  = !out_valid_reg || out_ready;
    assign emit       = (state_reg == ST_EMIT) && slot_free;
    assign div_start  = in_fire;
    assign cord_start = ((state_reg == ST_DIV) && div_stat.done) || (emit && !last_v);
    assign vy_calc    = 16'(center_y_reg) + round_q30(prod_reg);

    rpvg_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .divisor   (side_count_reg),
        .quotient  (div_quo),
        .remainder (div_rem),
        .stat      (div_stat)
    );

    rpvg_cordic u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cord_start),
        .turn    ({phase, (32 - ANGLE_BITS)'(0)}),
        .sin_q30 (cord_sin),
        .cos_q30 (cord_cos),
        .stat    (cord_stat)
    );

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    state_next = ST_CORD;
                end
            end
            ST_CORD:
            begin
                if (cord_stat.done)
                begin
                    state_next = ST_MULS;
                end
            end
            ST_MULS:
            begin
                state_next = ST_MULC;
            end
            ST_MULC:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (emit)
                begin
                    state_next = last_v ? ST_IDLE : ST_CORD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            acc_rot_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_fire)
            begin
                acc_rot_reg <= acc_rot_sum;
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // per-item and per-vertex payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            angle_reg  <= angle_wide[ANGLE_BITS-1:0];
            n_item_reg <= side_count_reg;
            i_reg      <= '0;
            q_reg      <= '0;
            r_reg      <= side_count_reg >> 1;
        end
        // one multiplier shared by sine and cosine
        if (state_reg == ST_MULS)
        begin
            prod_reg <= cord_sin * $signed({1'b0, radius_reg});
        end
        if (state_reg == ST_MULC)
        begin
            prod_reg    <= cord_cos * $signed({1'b0, radius_reg});
            vx_calc_reg <= 16'(center_x_reg) + round_q30(prod_reg);
        end
        if (emit)
        begin
            out_x_reg    <= vx_calc_reg[14:0];
            out_y_reg    <= vy_calc[14:0];
            out_idx_reg  <= 4'(i_reg);
            out_last_reg <= last_v;
            i_reg        <= i_reg + IDX_W'(1);
            q_reg        <= q_adv;
            r_reg        <= r_adv;
        end
    end

    assign out_valid    = out_valid_reg;
    assign vertex_x     = out_x_reg;
    assign vertex_y     = out_y_reg;
    assign vertex_index = out_idx_reg;
    assign last         = out_last_reg;

    // a new item starts the divider and drops ready for the whole polygon
    `RPVG_ASSERT_NEXT(a_busy_after_accept, in_fire, !in_ready)
    // the cordic is never restarted while it is still iterating
    `RPVG_ASSERT_IMP(a_cordic_start_idle, cord_start, !cord_stat.busy)
    // emitting the final vertex returns the sequencer to idle
    `RPVG_ASSERT_NEXT(a_last_to_idle, emit && last_v, in_ready && out_valid && last)

endmodule

`default_nettype wire
